// ----- sv/dlcc_pkg.sv -----
// Shared types and constants for the dirty line chunk coalescer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package dlcc_pkg;

    localparam int ACCUMULATORS_DEF = 4;
    localparam int QUEUE_DEPTH_DEF  = 4;

    localparam int ROW_W    = 12;
    localparam int LEFT_W   = 12;
    localparam int RIGHT_W  = 13;
    localparam int ROWS_W   = 8;
    localparam int BUF_W    = 4;
    localparam int OFFSET_W = 20;
    localparam int PROD_W   = ROWS_W + RIGHT_W;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 72;

    localparam logic [ROWS_W-1:0] CHUNK_LINES_RESET = 8'd16;
    localparam logic [ROWS_W-1:0] ROWS_CAP          = 8'hFF;

    // Input item kinds (tuser of the slave side).
    localparam logic KIND_LINE  = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    // Result kinds (tuser of the master side).
    localparam logic RES_PLACE = 1'b0;
    localparam logic RES_FLUSH = 1'b1;

    // One result on its way from the front to the back. For a placement,
    // left and right carry the window used for the width and rows carries
    // the rows already held; top is unused.
    typedef struct packed {
        logic                rkind;
        logic [BUF_W-1:0]    buf_idx;
        logic [LEFT_W-1:0]   left;
        logic [RIGHT_W-1:0]  right;
        logic [ROW_W-1:0]    top;
        logic [ROWS_W-1:0]   rows;
        logic                last;
    } op_t;

endpackage

`default_nettype wire

// ----- sv/dlcc_front.sv -----
// Front end of the coalescer (uses dlcc_pkg): takes input beats, holds the
// accumulators, chooses buffers, queues one result per cycle on q_ready.
`default_nettype none

module dlcc_front #(
    parameter int ACCUMULATORS = dlcc_pkg::ACCUMULATORS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             in_kind,
    input  wire logic [dlcc_pkg::ROW_W-1:0]       in_row,
    input  wire logic [dlcc_pkg::LEFT_W-1:0]      in_left,
    input  wire logic [dlcc_pkg::RIGHT_W-1:0]     in_right,
    input  wire logic [dlcc_pkg::ROWS_W-1:0]      chunk_lines,
    output logic                                  q_push,
    output dlcc_pkg::op_t                         q_data,
    input  wire logic                             q_ready
);

    localparam int IDX_W = (ACCUMULATORS > 1) ? $clog2(ACCUMULATORS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LINE,
        ST_PLACE,
        ST_FRAME
    } state_t;

    state_t                              state_reg;
    logic [dlcc_pkg::LEFT_W-1:0]         acc_left_reg  [ACCUMULATORS];
    logic [dlcc_pkg::RIGHT_W-1:0]        acc_right_reg [ACCUMULATORS];
    logic [dlcc_pkg::ROW_W-1:0]          acc_top_reg   [ACCUMULATORS];
    logic [dlcc_pkg::ROWS_W-1:0]         acc_rows_reg  [ACCUMULATORS];
    logic [dlcc_pkg::ROW_W-1:0]          row_reg;
    logic [dlcc_pkg::LEFT_W-1:0]         left_reg;
    logic [dlcc_pkg::RIGHT_W-1:0]        right_reg;
    logic [IDX_W-1:0]                    sel_reg;

    logic [ACCUMULATORS-1:0]             match_vec;
    logic [ACCUMULATORS-1:0]             free_vec;
    logic [ACCUMULATORS-1:0]             victim_vec;
    logic [ACCUMULATORS-1:0]             nz_vec;
    logic [IDX_W-1:0]                    match_idx;
    logic [IDX_W-1:0]                    free_idx;
    logic [IDX_W-1:0]                    victim_idx;
    logic [IDX_W-1:0]                    nz_idx;
    logic                                match_any;
    logic                                free_any;
    logic                                nz_any;
    logic                                nz_single;
    logic [IDX_W-1:0]                    a_idx;
    logic [dlcc_pkg::ROWS_W-1:0]         a_rows;
    logic                                flush_need;
    logic [IDX_W-1:0]                    p_idx;
    logic [dlcc_pkg::ROWS_W-1:0]         p_rows;
    logic                                place_now;

    // Per-accumulator classification; all comparisons are independent.
    always_comb
    begin
        for (int i = 0; i < ACCUMULATORS; i++)
        begin
            nz_vec[i]    = (acc_rows_reg[i] != '0);
            free_vec[i]  = !nz_vec[i];
            match_vec[i] = nz_vec[i] && (acc_left_reg[i] == left_reg)
                           && (acc_right_reg[i] == right_reg)
                           && (({1'b0, acc_top_reg[i]} + 13'(acc_rows_reg[i]))
                               == {1'b0, row_reg});
            // The fullest one, first on a tie: strictly above every lower
            // index and not below any higher index.
            victim_vec[i] = 1'b1;
            for (int j = 0; j < ACCUMULATORS; j++)
            begin
                if ((j < i) && !(acc_rows_reg[i] > acc_rows_reg[j]))
                begin
                    victim_vec[i] = 1'b0;
                end
                if ((j > i) && (acc_rows_reg[j] > acc_rows_reg[i]))
                begin
                    victim_vec[i] = 1'b0;
                end
            end
        end
    end

    // Lowest set bit of each vector.
    always_comb
    begin
        match_idx  = '0;
        free_idx   = '0;
        victim_idx = '0;
        nz_idx     = '0;
        for (int i = ACCUMULATORS - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                match_idx = IDX_W'(i);
            end
            if (free_vec[i])
            begin
                free_idx = IDX_W'(i);
            end
            if (victim_vec[i])
            begin
                victim_idx = IDX_W'(i);
            end
            if (nz_vec[i])
            begin
                nz_idx = IDX_W'(i);
            end
        end
    end

    assign match_any = |match_vec;
    assign free_any  = |free_vec;
    assign nz_any    = |nz_vec;
    assign nz_single = ((nz_vec & (nz_vec - 1'b1)) == '0);

    assign a_idx  = match_any ? match_idx : (free_any ? free_idx : victim_idx);
    assign a_rows = acc_rows_reg[a_idx];
    // No flush for a free buffer or a match that is not yet full.
    assign flush_need = (a_rows != '0)
                        && (!match_any || (a_rows == chunk_lines)
                            || (a_rows == dlcc_pkg::ROWS_CAP));

    assign place_now = ((state_reg == ST_LINE) && !flush_need) || (state_reg == ST_PLACE);
    assign p_idx     = (state_reg == ST_PLACE) ? sel_reg : a_idx;
    assign p_rows    = acc_rows_reg[p_idx];

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        q_push = 1'b0;
        q_data = '0;
        case (state_reg)
            ST_LINE, ST_PLACE:
            begin
                q_push = q_ready;
                if (place_now)
                begin
                    q_data.rkind   = dlcc_pkg::RES_PLACE;
                    q_data.buf_idx = dlcc_pkg::BUF_W'(p_idx);
                    q_data.left    = (p_rows == '0) ? left_reg  : acc_left_reg[p_idx];
                    q_data.right   = (p_rows == '0) ? right_reg : acc_right_reg[p_idx];
                    q_data.rows    = p_rows;
                    q_data.last    = 1'b1;
                end
                else
                begin
                    q_data.rkind   = dlcc_pkg::RES_FLUSH;
                    q_data.buf_idx = dlcc_pkg::BUF_W'(a_idx);
                    q_data.left    = acc_left_reg[a_idx];
                    q_data.right   = acc_right_reg[a_idx];
                    q_data.top     = acc_top_reg[a_idx];
                    q_data.rows    = a_rows;
                    q_data.last    = 1'b0;
                end
            end
            ST_FRAME:
            begin
                q_push         = q_ready && nz_any;
                q_data.rkind   = dlcc_pkg::RES_FLUSH;
                q_data.buf_idx = dlcc_pkg::BUF_W'(nz_idx);
                q_data.left    = acc_left_reg[nz_idx];
                q_data.right   = acc_right_reg[nz_idx];
                q_data.top     = acc_top_reg[nz_idx];
                q_data.rows    = acc_rows_reg[nz_idx];
                q_data.last    = nz_single;
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= '0;
            row_reg   <= '0;
            left_reg  <= '0;
            right_reg <= '0;
            for (int i = 0; i < ACCUMULATORS; i++)
            begin
                acc_left_reg[i]  <= '0;
                acc_right_reg[i] <= '0;
                acc_top_reg[i]   <= '0;
                acc_rows_reg[i]  <= '0;
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        row_reg   <= in_row;
                        left_reg  <= in_left;
                        right_reg <= in_right;
                        state_reg <= (in_kind == dlcc_pkg::KIND_FRAME) ? ST_FRAME : ST_LINE;
                    end
                end
                ST_LINE, ST_PLACE:
                begin
                    if (q_ready)
                    begin
                        if (place_now)
                        begin
                            if (p_rows == '0)
                            begin
                                acc_left_reg[p_idx]  <= left_reg;
                                acc_right_reg[p_idx] <= right_reg;
                                acc_top_reg[p_idx]   <= row_reg;
                            end
                            acc_rows_reg[p_idx] <= p_rows + 1'b1;
                            state_reg           <= ST_IDLE;
                        end
                        else
                        begin
                            sel_reg             <= a_idx;
                            acc_rows_reg[a_idx] <= '0;
                            state_reg           <= ST_PLACE;
                        end
                    end
                end
                ST_FRAME:
                begin
                    if (!nz_any)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (q_ready)
                    begin
                        acc_rows_reg[nz_idx] <= '0;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // A line that had to flush first starts a fresh chunk of one row.
    a_place_after_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PLACE && q_ready) |=> (acc_rows_reg[$past(sel_reg)] == 8'd1))
        else $error("buffer reused after a flush does not hold exactly one row");

    a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LINE && q_ready && flush_need)
        |=> (acc_rows_reg[$past(a_idx)] == '0) && (state_reg == ST_PLACE))
        else $error("line flush did not empty its buffer");

    a_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FRAME && q_push && q_data.last) |=> !nz_any)
        else $error("frame end marked last while buffers still hold rows");

endmodule

`default_nettype wire

// ----- sv/dlcc_queue.sv -----
// Short first-in first-out queue of result operations between the front
// and back ends of the coalescer. Uses dlcc_pkg for the operation type.
`default_nettype none

module dlcc_queue #(
    parameter int DEPTH = dlcc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire dlcc_pkg::op_t push_data,
    output logic               push_ready,
    output logic               pop_valid,
    output dlcc_pkg::op_t      pop_data,
    input  wire logic          pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dlcc_pkg::op_t       entry_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/dlcc_back.sv -----
// Back end of the coalescer: pops result operations, works out the row
// offset of a placement and holds the result beat in the output register.
// Uses dlcc_pkg.
`default_nettype none

module dlcc_back (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 q_valid,
    input  wire dlcc_pkg::op_t                        q_data,
    output logic                                      q_pop,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic [dlcc_pkg::OUT_DATA_W-1:0]           m_axis_tdata,
    output logic                                      m_axis_tuser,
    output logic                                      m_axis_tlast
);

    logic                                out_valid_reg;
    logic [dlcc_pkg::OUT_DATA_W-1:0]     out_data_reg;
    logic                                out_user_reg;
    logic                                out_last_reg;
    logic [dlcc_pkg::RIGHT_W-1:0]        width;
    logic [dlcc_pkg::PROD_W-1:0]         product;
    logic [dlcc_pkg::OFFSET_W-1:0]       offset;
    logic [dlcc_pkg::OUT_DATA_W-1:0]     data_next;

    assign q_pop = q_valid && (!out_valid_reg || m_axis_tready);

    // A reversed or empty span has zero width.
    assign width = ({1'b0, q_data.left} < q_data.right)
                   ? (q_data.right - {1'b0, q_data.left}) : '0;
    assign product = dlcc_pkg::PROD_W'(q_data.rows) * dlcc_pkg::PROD_W'(width);
    assign offset  = product[dlcc_pkg::OFFSET_W-1:0];

    always_comb
    begin
        data_next = '0;
        data_next[3:0] = q_data.buf_idx;
        if (q_data.rkind == dlcc_pkg::RES_FLUSH)
        begin
            data_next[15:4]  = q_data.left;
            data_next[28:16] = q_data.right;
            data_next[40:29] = q_data.top;
            data_next[48:41] = q_data.rows;
        end
        else
        begin
            data_next[68:49] = offset;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_data_reg <= data_next;
            out_user_reg <= q_data.rkind;
            out_last_reg <= q_data.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ----- sv/dirty_line_chunk_coalescer_unit.sv -----
// Top level of the dirty line chunk coalescer: configuration register and
// the front end, queue and back end. Depends on dlcc_pkg and the dlcc_ modules.
`default_nettype none

// The coalescer gathers dirty scanline spans into rectangular chunks for a
// panel transfer, using ACCUMULATORS staging buffers. A line beat (tuser 0)
// extends the lowest buffer with the same x range whose next row is this
// line, or else takes the lowest empty buffer, or else flushes the fullest
// buffer (lowest index on a tie) and reuses it; a buffer that already holds
// chunk_lines rows, or 255 rows, is flushed first. Every line ends with one
// placement beat giving the buffer and the pixel offset of the row (rows held
// times the span width), so a line gives one or two result beats. An
// end-of-frame beat (tuser 1) flushes every non-empty buffer in index order,
// one flush beat each, and gives no beat at all when every buffer is empty.
// tlast marks the final result beat of each input beat. A line beat is
// accepted, then decided and queued, after a flush if one is needed; an end
// of frame is accepted, flushes each non-empty buffer and ends on finding
// every buffer empty. No beat is taken until the front end is idle again;
// its decision sequencer queues one result per cycle while the queue has
// room. Results pass a short queue and a registered output stage, so the
// front end keeps working while the master side stalls until the queue
// fills. The user must write chunk_lines through cfg_wr_en and cfg_wr_data
// only while the block is idle, not enforced by the block; it resets to 16.
module dirty_line_chunk_coalescer_unit #(
    parameter int ACCUMULATORS = dlcc_pkg::ACCUMULATORS_DEF,
    parameter int QUEUE_DEPTH  = dlcc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // Configuration: chunk_lines.
    input  wire logic                                 cfg_wr_en,
    input  wire logic [dlcc_pkg::ROWS_W-1:0]          cfg_wr_data,
    // Input beats.
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // tdata from bit 0: line_row[11:0], span_left[23:12], span_right[36:24],
    // zero fill [39:37].
    input  wire logic [dlcc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // tuser: kind (0 dirty line, 1 end of frame).
    input  wire logic                                 s_axis_tuser,
    // Result beats.
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // tdata from bit 0: buffer_index[3:0], chunk_left[15:4], chunk_right[28:16],
    // chunk_top[40:29], chunk_rows[48:41], row_offset[68:49], zero fill [71:69].
    output logic [dlcc_pkg::OUT_DATA_W-1:0]           m_axis_tdata,
    // tuser: result_kind (0 placement, 1 flush). tlast: last.
    output logic                                      m_axis_tuser,
    output logic                                      m_axis_tlast
);

    logic [dlcc_pkg::ROWS_W-1:0]  chunk_lines_reg;
    logic                         q_push;
    dlcc_pkg::op_t                q_push_data;
    logic                         q_push_ready;
    logic                         q_pop_valid;
    dlcc_pkg::op_t                q_pop_data;
    logic                         q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_lines_reg <= dlcc_pkg::CHUNK_LINES_RESET;
        end
        else if (cfg_wr_en)
        begin
            chunk_lines_reg <= cfg_wr_data;
        end
    end

    dlcc_front #(
        .ACCUMULATORS (ACCUMULATORS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_kind     (s_axis_tuser),
        .in_row      (s_axis_tdata[11:0]),
        .in_left     (s_axis_tdata[23:12]),
        .in_right    (s_axis_tdata[36:24]),
        .chunk_lines (chunk_lines_reg),
        .q_push      (q_push),
        .q_data      (q_push_data),
        .q_ready     (q_push_ready)
    );

    dlcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .push_ready (q_push_ready),
        .pop_valid  (q_pop_valid),
        .pop_data   (q_pop_data),
        .pop        (q_pop)
    );

    dlcc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_pop_valid),
        .q_data        (q_pop_data),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // A placement always closes the results of its line.
    a_place_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == dlcc_pkg::RES_PLACE) |-> m_axis_tlast)
        else $error("placement beat without tlast");

    // Empty buffers are never flushed.
    a_flush_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == dlcc_pkg::RES_FLUSH)
        |-> (m_axis_tdata[48:41] != '0))
        else $error("flush beat with zero rows");

endmodule

`default_nettype wire
